// ===== design/encoder_position_pi_motor_drive_top_macros.svh =====
// Assertion macros shared by the encoder position PI drive design.
`ifndef ENCODER_POSITION_PI_MOTOR_DRIVE_TOP_MACROS_SVH
`define ENCODER_POSITION_PI_MOTOR_DRIVE_TOP_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define EPM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define EPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/epm_pkg.sv =====
// Types, constants and the duty lookup for the encoder position PI drive.
package epm_pkg;

  localparam int MUL_W       = 24;
  localparam int IMAG_W      = 2 * MUL_W;
  localparam int QUO_W       = 23;
  localparam int ACC_W       = 51;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 24;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] CFG_OFFSET     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_FULL_SCALE = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_PROP_GAIN  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_INTEG_GAIN = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_TICK_MS    = 3'd4;

  localparam logic signed [15:0] RST_OFFSET     = 16'sd0;
  localparam logic [15:0]        RST_FULL_SCALE = 16'd2826;
  localparam logic [23:0]        RST_PROP_GAIN  = 24'd3276800;
  localparam logic [23:0]        RST_INTEG_GAIN = 24'd6554;
  localparam logic [9:0]         RST_TICK_MS    = 10'd10;

  localparam logic signed [12:0] POS_MIN     = -13'sd4096;
  localparam logic signed [12:0] POS_MAX     = 13'sd4095;
  localparam logic [QUO_W-1:0]   QUO_NEG_LIM = 23'd4096;
  localparam logic [QUO_W-1:0]   QUO_POS_LIM = 23'd4095;
  localparam logic [MUL_W-1:0]   PCT_SCALE   = 24'd100;
  localparam logic [3:0]         MAX_MS      = 4'd10;
  localparam logic [ACC_W-1:0]   GAIN_DIV    = 51'd6553600;
  localparam logic [12:0]        DUTY_MAX    = 13'd6562;

  typedef struct packed {
    logic signed [15:0] offset;
    logic [15:0]        full_scale;
    logic [23:0]        prop_gain;
    logic [23:0]        integ_gain;
    logic [9:0]         tick_ms;
  } cfg_t;

  // Declared high field first so that duty lands in the low bits.
  typedef struct packed {
    logic signed [13:0] err;
    logic signed [12:0] pos;
    logic               dir;
    logic [12:0]        duty;
  } result_t;

  // Whole drive milliseconds to PWM compare counts at 656.25 counts per ms.
  function automatic logic [12:0] duty_of(input logic [3:0] ms);
    logic [12:0] d;
    case (ms)
      4'd0:    d = 13'd0;
      4'd1:    d = 13'd656;
      4'd2:    d = 13'd1312;
      4'd3:    d = 13'd1968;
      4'd4:    d = 13'd2625;
      4'd5:    d = 13'd3281;
      4'd6:    d = 13'd3937;
      4'd7:    d = 13'd4593;
      4'd8:    d = 13'd5250;
      4'd9:    d = 13'd5906;
      4'd10:   d = 13'd6562;
      default: d = 13'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== design/epm_cfg.sv =====
// Configuration register file for the encoder position PI drive.
module epm_cfg
  import epm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_ADDR_W-1:0] addr,
  input  logic [CFG_DATA_W-1:0] wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (addr)
        CFG_OFFSET:     cfg_nxt.offset     = $signed(wdata[15:0]);
        CFG_FULL_SCALE: cfg_nxt.full_scale = wdata[15:0];
        CFG_PROP_GAIN:  cfg_nxt.prop_gain  = wdata;
        CFG_INTEG_GAIN: cfg_nxt.integ_gain = wdata;
        CFG_TICK_MS:    cfg_nxt.tick_ms    = wdata[9:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.offset     <= RST_OFFSET;
      cfg_r.full_scale <= RST_FULL_SCALE;
      cfg_r.prop_gain  <= RST_PROP_GAIN;
      cfg_r.integ_gain <= RST_INTEG_GAIN;
      cfg_r.tick_ms    <= RST_TICK_MS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== design/epm_mul.sv =====
// Shared unsigned multiplier with a registered product.
module epm_mul
  import epm_pkg::*;
(
  input  logic               clk,
  input  logic [MUL_W-1:0]   a,
  input  logic [MUL_W-1:0]   b,
  output logic [IMAG_W-1:0]  p_r
);

  logic [IMAG_W-1:0] p_nxt;

  assign p_nxt = a * b;

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

endmodule

// ===== design/epm_core.sv =====
// Sequencer and datapath: divider, integral update and gain evaluation.
module epm_core
  import epm_pkg::*;
#(
  parameter int INTEGRAL_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_target,
  input  logic signed [15:0] in_count,
  output logic              res_valid,
  input  logic              res_ready,
  output result_t           res
);

  localparam int SUM_W = ((INTEGRAL_WIDTH > 24) ? INTEGRAL_WIDTH : 24) + 1;
  localparam logic signed [SUM_W-1:0] IMAX =
    SUM_W'((64'sd1 <<< (INTEGRAL_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] IMIN = -IMAX - SUM_W'(1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_M100  = 4'd1;
  localparam logic [3:0] S_DINIT = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_POS   = 4'd4;
  localparam logic [3:0] S_EMUL  = 4'd5;
  localparam logic [3:0] S_INT   = 4'd6;
  localparam logic [3:0] S_IHI   = 4'd7;
  localparam logic [3:0] S_ILO   = 4'd8;
  localparam logic [3:0] S_PG    = 4'd9;
  localparam logic [3:0] S_GAIN  = 4'd10;
  localparam logic [3:0] S_SIGN  = 4'd11;
  localparam logic [3:0] S_MS    = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0]                       state_r, state_nxt;
  logic [4:0]                       cnt_r, cnt_nxt;
  logic [7:0]                       tgt_r, tgt_nxt;
  logic [16:0]                      dmag_r, dmag_nxt;
  logic                             dneg_r, dneg_nxt;
  logic [16:0]                      rem_r, rem_nxt;
  logic [QUO_W-1:0]                 quo_r, quo_nxt;
  logic signed [12:0]               pos_r, pos_nxt;
  logic signed [13:0]               err_r, err_nxt;
  logic [13:0]                      emag_r, emag_nxt;
  logic signed [INTEGRAL_WIDTH-1:0] integral_r, integral_nxt;
  logic [IMAG_W-1:0]                imag_r, imag_nxt;
  logic                             ineg_r, ineg_nxt;
  logic                             ipos_r, ipos_nxt;
  logic [13:0]                      phi_r, phi_nxt;
  logic signed [ACC_W-1:0]          acc_r, acc_nxt;
  logic [ACC_W-1:0]                 m_r, m_nxt;
  logic [3:0]                       ms_r, ms_nxt;
  logic                             dir_r, dir_nxt;

  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [IMAG_W-1:0]  mul_p;

  logic signed [16:0]       diff;
  logic [15:0]              fs_eff;
  logic [16:0]              rem_sh;
  logic [17:0]              rem_sub;
  logic signed [12:0]       pos_v;
  logic signed [13:0]       err_v;
  logic signed [SUM_W-1:0]  padd;
  logic signed [SUM_W-1:0]  isum;
  logic signed [SUM_W-1:0]  isat;
  logic signed [SUM_W-1:0]  imag_s;
  logic signed [ACC_W-1:0]  iterm;
  logic signed [ACC_W-1:0]  pterm;

  epm_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_OUT);
  assign res.duty  = duty_of(ms_r);
  assign res.dir   = dir_r;
  assign res.pos   = pos_r;
  assign res.err   = err_r;

  assign diff    = 17'(cfg.offset) - 17'(in_count);
  assign fs_eff  = (cfg.full_scale == 16'd0) ? 16'd1 : cfg.full_scale;
  assign rem_sh  = {rem_r[15:0], quo_r[QUO_W-1]};
  assign rem_sub = {1'b0, rem_sh} - {2'b00, fs_eff};

  always_comb begin
    if (dneg_r) begin
      pos_v = (quo_r > QUO_NEG_LIM) ? POS_MIN : $signed(13'd0 - quo_r[12:0]);
    end else begin
      pos_v = (quo_r > QUO_POS_LIM) ? POS_MAX : $signed(quo_r[12:0]);
    end
    err_v = $signed({6'b000000, tgt_r}) - 14'(pos_v);
  end

  // Integral update: err * tick comes back as a magnitude from the multiplier.
  always_comb begin
    padd = $signed(SUM_W'(mul_p[QUO_W-1:0]));
    if (err_r[13]) begin
      padd = -padd;
    end
    isum = SUM_W'(integral_r) + padd;
    if (isum > IMAX) begin
      isat = IMAX;
    end else if (isum < IMIN) begin
      isat = IMIN;
    end else begin
      isat = isum;
    end
    imag_s = (isat < 0) ? -isat : isat;
  end

  always_comb begin
    iterm = $signed(ACC_W'({phi_r, 24'd0}) + ACC_W'(mul_p));
    pterm = $signed(ACC_W'(mul_p[37:0]));
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    tgt_nxt      = tgt_r;
    dmag_nxt     = dmag_r;
    dneg_nxt     = dneg_r;
    rem_nxt      = rem_r;
    quo_nxt      = quo_r;
    pos_nxt      = pos_r;
    err_nxt      = err_r;
    emag_nxt     = emag_r;
    integral_nxt = integral_r;
    imag_nxt     = imag_r;
    ineg_nxt     = ineg_r;
    ipos_nxt     = ipos_r;
    phi_nxt      = phi_r;
    acc_nxt      = acc_r;
    m_nxt        = m_r;
    ms_nxt       = ms_r;
    dir_nxt      = dir_r;
    mul_a        = '0;
    mul_b        = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          tgt_nxt   = in_target;
          dneg_nxt  = diff[16];
          dmag_nxt  = diff[16] ? 17'(-diff) : 17'(diff);
          state_nxt = S_M100;
        end
      end
      S_M100: begin
        mul_a     = MUL_W'(dmag_r);
        mul_b     = PCT_SCALE;
        state_nxt = S_DINIT;
      end
      S_DINIT: begin
        quo_nxt   = mul_p[QUO_W-1:0];
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        // Restoring division, one quotient bit per cycle.
        if (!rem_sub[17]) begin
          rem_nxt = rem_sub[16:0];
          quo_nxt = {quo_r[QUO_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          quo_nxt = {quo_r[QUO_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(QUO_W - 1)) begin
          state_nxt = S_POS;
        end
      end
      S_POS: begin
        pos_nxt   = pos_v;
        err_nxt   = err_v;
        emag_nxt  = err_v[13] ? 14'(-err_v) : 14'(err_v);
        state_nxt = S_EMUL;
      end
      S_EMUL: begin
        mul_a     = MUL_W'(emag_r);
        mul_b     = MUL_W'(cfg.tick_ms);
        state_nxt = S_INT;
      end
      S_INT: begin
        integral_nxt = INTEGRAL_WIDTH'(isat);
        ineg_nxt     = (isat < 0);
        ipos_nxt     = (isat > 0);
        imag_nxt     = IMAG_W'(imag_s);
        state_nxt    = S_IHI;
      end
      S_IHI: begin
        mul_a     = cfg.integ_gain;
        mul_b     = imag_r[IMAG_W-1:MUL_W];
        state_nxt = S_ILO;
      end
      S_ILO: begin
        mul_a   = cfg.integ_gain;
        mul_b   = imag_r[MUL_W-1:0];
        phi_nxt = mul_p[13:0];
        // An integral term this large outweighs any proportional term.
        if (|mul_p[IMAG_W-1:14]) begin
          dir_nxt   = ipos_r;
          ms_nxt    = MAX_MS;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_PG;
        end
      end
      S_PG: begin
        mul_a     = cfg.prop_gain;
        mul_b     = MUL_W'(emag_r);
        acc_nxt   = ineg_r ? -iterm : iterm;
        state_nxt = S_GAIN;
      end
      S_GAIN: begin
        acc_nxt   = err_r[13] ? (acc_r - pterm) : (acc_r + pterm);
        state_nxt = S_SIGN;
      end
      S_SIGN: begin
        dir_nxt   = (acc_r > 0);
        m_nxt     = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
        ms_nxt    = '0;
        state_nxt = S_MS;
      end
      S_MS: begin
        // Whole milliseconds by repeated subtraction, capped at the maximum drive.
        if ((ms_r != MAX_MS) && (m_r >= GAIN_DIV)) begin
          m_nxt  = m_r - GAIN_DIV;
          ms_nxt = ms_r + 4'd1;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      integral_r <= '0;
    end else begin
      state_r    <= state_nxt;
      integral_r <= integral_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    tgt_r  <= tgt_nxt;
    dmag_r <= dmag_nxt;
    dneg_r <= dneg_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    pos_r  <= pos_nxt;
    err_r  <= err_nxt;
    emag_r <= emag_nxt;
    imag_r <= imag_nxt;
    ineg_r <= ineg_nxt;
    ipos_r <= ipos_nxt;
    phi_r  <= phi_nxt;
    acc_r  <= acc_nxt;
    m_r    <= m_nxt;
    ms_r   <= ms_nxt;
    dir_r  <= dir_nxt;
  end

endmodule

// ===== design/encoder_position_pi_motor_drive_top.sv =====
// Top level of the encoder position PI drive: stream ports, output register, checks.
// Each input transaction carries a target position and a raw encoder count and yields
// one output transaction with the PWM compare value, the drive direction, the measured
// position and the position error. The block works on one transaction at a time. Its
// steps are the 23-step restoring divider for the position and, unless the integral term
// saturates the drive, the drive-time subtract loop of up to ten steps; all products go
// through one shared 24x24 multiplier. The input is taken again in the cycle after the
// result enters the output register, which holds it until the sink takes it. The error
// integral persists across transactions and is cleared only by reset.
`include "encoder_position_pi_motor_drive_top_macros.svh"

module encoder_position_pi_motor_drive_top
  import epm_pkg::*;
#(
  parameter int INTEGRAL_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [7:0] target_percent, [23:8] encoder_count
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [12:0] duty_counts, [13] drive_direction, [26:14] position_percent,
  // [40:27] position_error, [47:41] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t    cfg;
  result_t res;
  logic    res_valid;
  logic    res_ready;
  logic    res_fire;
  logic    out_valid_r, out_valid_nxt;
  result_t out_r, out_nxt;

  epm_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (cfg_wr_en),
    .addr  (cfg_addr),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  epm_core #(
    .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_target (in_tdata[7:0]),
    .in_count  ($signed(in_tdata[23:8])),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || out_tready;
  assign res_fire  = res_valid && res_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (res_fire) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_r};

  `EPM_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "input taken while busy")
  `EPM_ASSERT_NOW(a_no_accept_on_result, res_fire, !(in_tvalid && in_tready), "accept during result load")
  `EPM_ASSERT_NOW(a_duty_in_range, out_tvalid, out_r.duty <= DUTY_MAX, "duty above ten ms")

endmodule
